// File: design/flar_pkg.sv
package flar_pkg;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 20;
   localparam int NORM_STAGES  = 6;
   localparam int NORM_TOP     = 48;          // normalised value lands in [2^48, 2^49)
   localparam int XW           = 52;          // CORDIC x/y width, signed
   localparam int ACC_W        = 25;          // angle accumulator, 1/65536 degree, signed
   localparam int ANG_W        = 16;
   localparam int ANGLE_MAX    = 46080;
   localparam int ACC_QUARTER  = 90 * 65536;  // credited when the pair is turned by 90 deg
   localparam int ROUND_BITS   = 8;

   // ratio datapath
   localparam int RATIO_BITS   = 16;
   localparam int FRAC_BITS    = 12;
   localparam int SAT_SHIFT    = RATIO_BITS - FRAC_BITS;

   // pipeline depths, counted from the input register
   localparam int ANG_LAT      = 3 + NORM_STAGES + CORDIC_STEPS;
   localparam int RAT_LAT      = 3 + RATIO_BITS;
   localparam int RAT_PAD      = ANG_LAT - RAT_LAT;

   typedef struct packed {
      logic signed [XW-1:0]    x;
      logic signed [XW-1:0]    y;
      logic signed [ACC_W-1:0] acc;
      logic                    degen;
   } cordic_type;

   typedef struct packed {
      logic [ANG_W-1:0] angle;
      logic             degen;
   } angle_res_type;

   typedef struct packed {
      logic [RATIO_BITS-1:0] ratio;
      logic                  coincide;
   } ratio_res_type;

   // arctan(2^-i) in 1/65536 degree
   function automatic logic signed [ACC_W-1:0] atan_val(input int idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         0:  v = ACC_W'(2949120);
         1:  v = ACC_W'(1740967);
         2:  v = ACC_W'(919879);
         3:  v = ACC_W'(466945);
         4:  v = ACC_W'(234379);
         5:  v = ACC_W'(117304);
         6:  v = ACC_W'(58666);
         7:  v = ACC_W'(29335);
         8:  v = ACC_W'(14668);
         9:  v = ACC_W'(7334);
         10: v = ACC_W'(3667);
         11: v = ACC_W'(1833);
         12: v = ACC_W'(917);
         13: v = ACC_W'(458);
         14: v = ACC_W'(229);
         15: v = ACC_W'(115);
         16: v = ACC_W'(57);
         17: v = ACC_W'(29);
         18: v = ACC_W'(14);
         19: v = ACC_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: design/flar_cordic_cell.sv
module flar_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                ce,
   input  flar_pkg::cordic_type cell_in,
   output flar_pkg::cordic_type cell_out
);
   import flar_pkg::*;

   cordic_type              cell_ff;
   cordic_type              cell_nx_in;
   logic signed [XW-1:0]    xs;
   logic signed [XW-1:0]    ys;

   // one vectoring rotation, direction from the sign of y
   always_comb begin
      xs         = cell_in.x >>> STEP;
      ys         = cell_in.y >>> STEP;
      cell_nx_in = cell_in;
      if (!cell_in.y[XW-1]) begin
         cell_nx_in.x   = cell_in.x + ys;
         cell_nx_in.y   = cell_in.y - xs;
         cell_nx_in.acc = cell_in.acc + atan_val(STEP);
      end else begin
         cell_nx_in.x   = cell_in.x - ys;
         cell_nx_in.y   = cell_in.y + xs;
         cell_nx_in.acc = cell_in.acc - atan_val(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         cell_ff <= cell_nx_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// File: design/flar_div_cell.sv
module flar_div_cell #(
   parameter int RW  = 49,
   parameter int DW  = 33,
   parameter int BIT = 0
) (
   input  logic                                  clock,
   input  logic                                  ce,
   input  logic [RW-1:0]                         rem_in,
   input  logic [DW-1:0]                         den_in,
   input  logic [flar_pkg::RATIO_BITS-1:0]       q_in,
   output logic [RW-1:0]                         rem_out,
   output logic [DW-1:0]                         den_out,
   output logic [flar_pkg::RATIO_BITS-1:0]       q_out
);
   import flar_pkg::*;

   logic [RW-1:0]         rem_ff, rem_in_nx;
   logic [DW-1:0]         den_ff;
   logic [RATIO_BITS-1:0] q_ff, q_in_nx;
   logic [RW-1:0]         trial;

   // restoring step: one quotient bit
   always_comb begin
      trial     = RW'(den_in) << BIT;
      rem_in_nx = rem_in;
      q_in_nx   = q_in;
      if (rem_in >= trial) begin
         rem_in_nx    = rem_in - trial;
         q_in_nx[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff <= rem_in_nx;
         den_ff <= den_in;
         q_ff   <= q_in_nx;
      end
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign q_out   = q_ff;

endmodule

// File: design/flar_angle.sv
module flar_angle #(
   parameter int CW = 16
) (
   input  logic                    clock,
   input  logic                    ce,
   input  logic signed [CW:0]      a_x,
   input  logic signed [CW:0]      a_y,
   input  logic signed [CW:0]      b_x,
   input  logic signed [CW:0]      b_y,
   output flar_pkg::angle_res_type res
);
   import flar_pkg::*;

   localparam int PW = 2 * CW + 2;

   logic signed [PW-1:0] pxx_ff, pyy_ff, pxy_ff, pyx_ff;
   logic                 deg1_ff;
   logic signed [PW:0]   dot, crs;
   logic [PW:0]          crs_mag, dot_neg;
   cordic_type           nrm_ff [0:NORM_STAGES];
   cordic_type           nrm_in [0:NORM_STAGES];
   cordic_type           chain [0:CORDIC_STEPS];
   angle_res_type        res_ff, res_in;
   logic [ACC_W-1:0]     acc_pos;
   logic [ACC_W:0]       acc_rnd;
   logic [ACC_W-ROUND_BITS:0] ang_full;

   // products of the two vectors
   always_ff @(posedge clock) begin
      if (ce) begin
         pxx_ff  <= PW'(a_x * b_x);
         pyy_ff  <= PW'(a_y * b_y);
         pxy_ff  <= PW'(a_x * b_y);
         pyx_ff  <= PW'(a_y * b_x);
         deg1_ff <= ((a_x == '0) && (a_y == '0)) || ((b_x == '0) && (b_y == '0));
      end
   end

   // dot and |cross|, obtuse pairs turned by a quarter
   always_comb begin
      dot     = (PW+1)'(pxx_ff) + (PW+1)'(pyy_ff);
      crs     = (PW+1)'(pxy_ff) - (PW+1)'(pyx_ff);
      crs_mag = crs[PW] ? (PW+1)'(-crs) : (PW+1)'(crs);
      dot_neg = (PW+1)'(-dot);
      nrm_in[0].degen = deg1_ff;
      if (dot[PW]) begin
         nrm_in[0].x   = XW'(crs_mag);
         nrm_in[0].y   = XW'(dot_neg);
         nrm_in[0].acc = ACC_W'(ACC_QUARTER);
      end else begin
         nrm_in[0].x   = XW'(crs_mag) & '0 | XW'(dot[PW-1:0]);
         nrm_in[0].y   = XW'(crs_mag);
         nrm_in[0].acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         nrm_ff[0] <= nrm_in[0];
      end
   end

   // binary normalisation: shifts of 32, 16, 8, 4, 2, 1
   for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
      localparam int SH = 32 >> k;
      logic [XW-1:0] orv;
      always_comb begin
         orv          = nrm_ff[k].x | nrm_ff[k].y;
         nrm_in[k+1]  = nrm_ff[k];
         if (orv[XW-1:NORM_TOP+1-SH] == '0) begin
            nrm_in[k+1].x = nrm_ff[k].x <<< SH;
            nrm_in[k+1].y = nrm_ff[k].y <<< SH;
         end
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            nrm_ff[k+1] <= nrm_in[k+1];
         end
      end
   end

   assign chain[0] = nrm_ff[NORM_STAGES];

   // rotation cells
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      flar_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .ce       (ce),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // round to 1/256 degree and clamp
   always_comb begin
      acc_pos  = chain[CORDIC_STEPS].acc[ACC_W-1] ? '0 : chain[CORDIC_STEPS].acc;
      acc_rnd  = (ACC_W+1)'(acc_pos) + (ACC_W+1)'(1 << (ROUND_BITS - 1));
      ang_full = acc_rnd[ACC_W:ROUND_BITS];
      res_in.degen = chain[CORDIC_STEPS].degen;
      if (chain[CORDIC_STEPS].degen) begin
         res_in.angle = '0;
      end else if (ang_full > (ACC_W-ROUND_BITS+1)'(ANGLE_MAX)) begin
         res_in.angle = ANG_W'(ANGLE_MAX);
      end else begin
         res_in.angle = ANG_W'(ang_full);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: design/face_landmark_angles_ratio.sv
// Channel | Dir | tdata (low bit up)                              | tuser (low bit up)
// req     | in  | left_eye_x, left_eye_y, right_eye_x, right_eye_y, | -
//         |     | nose_x, nose_y (16 bits each)                     |
// rsp     | out | left_angle, right_angle, nose_ratio (16 each)     | left_degenerate,
//         |     |                                                   | right_degenerate,
//         |     |                                                   | eyes_coincide
//
// One word per cycle while rsp does not stall. A word passes the input register, the
// product/dot stages, 6 normalisation stages, the 20 CORDIC rotation cells and rounding.
// Synchronous active-high reset clears only the valid line.
// The whole pipeline advances whenever the output register is empty or being taken;
// a stall on rsp holds every stage and drops req_tready.
module face_landmark_angles_ratio #(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // left_eye_x, left_eye_y, right_eye_x, right_eye_y,
                                    // nose_x, nose_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // left_angle, right_angle, nose_ratio
   output logic [2:0]  rsp_tuser    // left_degenerate, right_degenerate, eyes_coincide
);
   import flar_pkg::*;

   localparam int FW = 16;
   localparam int CW = (COORD_BITS < FW) ? COORD_BITS : FW;
   localparam int PW = 2 * CW + 2;
   localparam int DW = 2 * CW + 1;
   localparam int RW = 2 * CW + 17;

   logic                 ce;
   logic                 vld_ff [0:ANG_LAT];
   logic [CW-1:0]        lx_ff, ly_ff, rx_ff, ry_ff, nx_ff, ny_ff;
   logic signed [CW:0]   lrx, lry, nrx, nry, rlx, rly, nlx, nly, dx, dy;
   angle_res_type        left_res, right_res;

   logic signed [PW-1:0] pde_x_ff, pde_y_ff, pee_x_ff, pee_y_ff;
   logic signed [PW:0]   pd;
   logic [DW-1:0]        num, den;
   logic [RW-1:0]        rem [0:RATIO_BITS];
   logic [DW-1:0]        dvs [0:RATIO_BITS];
   logic [RATIO_BITS-1:0] quo [0:RATIO_BITS];
   logic [RW-1:0]        rem0_ff;
   logic [DW-1:0]        den0_ff;
   logic                 sat_ff [0:RATIO_BITS];
   logic                 coi_ff [0:RATIO_BITS+1];
   ratio_res_type        rat_in;
   ratio_res_type        rat_dly_ff [0:RAT_PAD];

   assign ce         = !vld_ff[ANG_LAT] || rsp_tready;
   assign req_tready = ce;

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ANG_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (ce) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= ANG_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // input register, coordinates masked to CW bits
   always_ff @(posedge clock) begin
      if (ce) begin
         lx_ff <= req_tdata[0*FW +: CW];
         ly_ff <= req_tdata[1*FW +: CW];
         rx_ff <= req_tdata[2*FW +: CW];
         ry_ff <= req_tdata[3*FW +: CW];
         nx_ff <= req_tdata[4*FW +: CW];
         ny_ff <= req_tdata[5*FW +: CW];
      end
   end

   // difference vectors
   always_comb begin
      lrx = signed'({1'b0, lx_ff}) - signed'({1'b0, rx_ff});
      lry = signed'({1'b0, ly_ff}) - signed'({1'b0, ry_ff});
      nrx = signed'({1'b0, nx_ff}) - signed'({1'b0, rx_ff});
      nry = signed'({1'b0, ny_ff}) - signed'({1'b0, ry_ff});
      rlx = signed'({1'b0, rx_ff}) - signed'({1'b0, lx_ff});
      rly = signed'({1'b0, ry_ff}) - signed'({1'b0, ly_ff});
      nlx = signed'({1'b0, nx_ff}) - signed'({1'b0, lx_ff});
      nly = signed'({1'b0, ny_ff}) - signed'({1'b0, ly_ff});
      dx  = signed'({1'b0, lx_ff}) - signed'({1'b0, nx_ff});
      dy  = signed'({1'b0, ly_ff}) - signed'({1'b0, ny_ff});
   end

   flar_angle #(.CW(CW)) u_left (
      .clock (clock), .ce (ce),
      .a_x (lrx), .a_y (lry), .b_x (nrx), .b_y (nry),
      .res (left_res)
   );

   flar_angle #(.CW(CW)) u_right (
      .clock (clock), .ce (ce),
      .a_x (rlx), .a_y (rly), .b_x (nlx), .b_y (nly),
      .res (right_res)
   );

   // ratio products
   always_ff @(posedge clock) begin
      if (ce) begin
         pde_x_ff <= PW'(dx * rlx);
         pde_y_ff <= PW'(dy * rly);
         pee_x_ff <= PW'(rlx * rlx);
         pee_y_ff <= PW'(rly * rly);
      end
   end

   // numerator and denominator
   always_comb begin
      pd  = (PW+1)'(pde_x_ff) + (PW+1)'(pde_y_ff);
      num = pd[PW] ? DW'(-pd) : DW'(pd);
      den = DW'(pee_x_ff) + DW'(pee_y_ff);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem0_ff   <= RW'(num) << FRAC_BITS;
         den0_ff   <= den;
      end
   end

   assign rem[0] = rem0_ff;
   assign dvs[0] = den0_ff;
   assign quo[0] = '0;

   // divider cells, one quotient bit each, top bit first
   for (genvar k = 0; k < RATIO_BITS; k++) begin : g_div
      flar_div_cell #(.RW(RW), .DW(DW), .BIT(RATIO_BITS - 1 - k)) u_div (
         .clock   (clock),
         .ce      (ce),
         .rem_in  (rem[k]),
         .den_in  (dvs[k]),
         .q_in    (quo[k]),
         .rem_out (rem[k+1]),
         .den_out (dvs[k+1]),
         .q_out   (quo[k+1])
      );
   end

   // flags ride beside the divider; coincide starts one stage earlier
   always_ff @(posedge clock) begin
      if (ce) begin
         coi_ff[0] <= (rlx == '0) && (rly == '0);
         sat_ff[0] <= (RW'(num) >= (RW'(den) << SAT_SHIFT));
         for (int i = 1; i <= RATIO_BITS; i++) sat_ff[i] <= sat_ff[i-1];
         for (int i = 1; i <= RATIO_BITS + 1; i++) coi_ff[i] <= coi_ff[i-1];
      end
   end

   // final ratio select
   always_comb begin
      rat_in.coincide = coi_ff[RATIO_BITS+1];
      if (coi_ff[RATIO_BITS+1]) begin
         rat_in.ratio = '0;
      end else if (sat_ff[RATIO_BITS]) begin
         rat_in.ratio = '1;
      end else begin
         rat_in.ratio = quo[RATIO_BITS];
      end
   end

   // delay to line up with the angle path
   always_ff @(posedge clock) begin
      if (ce) begin
         rat_dly_ff[0] <= rat_in;
         for (int i = 1; i <= RAT_PAD; i++) rat_dly_ff[i] <= rat_dly_ff[i-1];
      end
   end

   assign rsp_tvalid = vld_ff[ANG_LAT];
   assign rsp_tdata  = {rat_dly_ff[RAT_PAD].ratio, right_res.angle, left_res.angle};
   assign rsp_tuser  = {rat_dly_ff[RAT_PAD].coincide, right_res.degen, left_res.degen};

endmodule
